FILE: rtl/core/sql_subset_lexer_defines.svh
// ----------------------------------------------------------------------------
// sql_subset_lexer_defines : assertion macros shared by the lexer core
// ----------------------------------------------------------------------------
`ifndef SQL_SUBSET_LEXER_DEFINES_SVH
`define SQL_SUBSET_LEXER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SQLL_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("sql lexer check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SQLL_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("sql lexer check failed");

`endif

FILE: rtl/core/sqll_pkg.sv
// ----------------------------------------------------------------------------
// sqll_pkg : types, codes and character classes of the SQL subset lexer
// Token kinds, keyword table, byte classification and the queue entry type.
// ----------------------------------------------------------------------------
package sqll_pkg;

    localparam int OUT_W = 16;

    localparam logic [4:0] KIND_END    = 5'd0;
    localparam logic [4:0] KIND_ID     = 5'd1;
    localparam logic [4:0] KIND_STRING = 5'd2;
    localparam logic [4:0] KIND_INT    = 5'd3;
    localparam logic [4:0] KIND_KW0    = 5'd4;
    localparam logic [4:0] KIND_COMMA  = 5'd10;
    localparam logic [4:0] KIND_LPAREN = 5'd11;
    localparam logic [4:0] KIND_RPAREN = 5'd12;
    localparam logic [4:0] KIND_STAR   = 5'd13;
    localparam logic [4:0] KIND_EQUAL  = 5'd14;
    localparam logic [4:0] KIND_SEMI   = 5'd15;
    localparam logic [4:0] KIND_ERROR  = 5'd16;
    localparam logic [4:0] KIND_NONE   = 5'd0;

    localparam int NUM_KW = 6;

    // Keyword text, first character in the top byte, padded with spaces.
    localparam logic [47:0] KW_TEXT [NUM_KW] = '{
        "select", "insert", "into  ", "values", "from  ", "where "
    };
    localparam logic [2:0] KW_LEN [NUM_KW] = '{3'd6, 3'd6, 3'd4, 3'd6, 3'd4, 3'd5};

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic [4:0]       kind;
        logic [OUT_W-1:0] start;
        logic [OUT_W-1:0] len;
    } tok_t;

    // Results caused by one input item: r0 alone, or r0 then r1.
    typedef struct packed {
        logic two;
        tok_t r0;
        tok_t r1;
    } entry_t;

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == " " || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic is_ident_char(input logic [7:0] c);
        return is_letter(c) || is_digit(c) || c == "_";
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    endfunction

    function automatic logic [4:0] punct_kind(input logic [7:0] c);
        logic [4:0] k;
        unique case (c)
            ",":     k = KIND_COMMA;
            "(":     k = KIND_LPAREN;
            ")":     k = KIND_RPAREN;
            "*":     k = KIND_STAR;
            "=":     k = KIND_EQUAL;
            ";":     k = KIND_SEMI;
            default: k = KIND_NONE;
        endcase
        return k;
    endfunction

    // One bit per keyword: its character at idx equals the lowered byte.
    function automatic logic [NUM_KW-1:0] kw_hit(input logic [2:0] idx,
                                                 input logic [7:0] lc);
        logic [NUM_KW-1:0] hit;
        logic [7:0]        ch;
        for (int k = 0; k < NUM_KW; k++) begin
            ch = 8'h00;
            for (int j = 0; j < 6; j++) begin
                if (idx == 3'(j)) begin
                    ch = KW_TEXT[k][47-8*j -: 8];
                end
            end
            hit[k] = (idx < KW_LEN[k]) && (ch == lc);
        end
        return hit;
    endfunction

endpackage

FILE: rtl/core/sqll_front.sv
// ----------------------------------------------------------------------------
// sqll_front : byte classifier and token scanner
// Tracks the scan mode, position and keyword match per accepted byte and
// hands the token results that a byte closes to the queue as one entry.
// ----------------------------------------------------------------------------
module sqll_front #(
    parameter int POS_WIDTH = 16
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            accept,
    input  logic [7:0]      in_byte,
    input  logic            in_end,
    output logic            push,
    output sqll_pkg::entry_t push_entry
);
    import sqll_pkg::*;

    localparam int PW = POS_WIDTH;
    localparam int CW = (PW > OUT_W) ? PW : OUT_W;
    localparam logic [PW-1:0] POS_MAX = {PW{1'b1}};

    localparam logic [2:0] MODE_IDLE   = 3'd0;
    localparam logic [2:0] MODE_IDENT  = 3'd1;
    localparam logic [2:0] MODE_NUMBER = 3'd2;
    localparam logic [2:0] MODE_STRING = 3'd3;
    localparam logic [2:0] MODE_ERROR  = 3'd4;

    logic [2:0]        mode_reg,  mode_next;
    logic [PW-1:0]     pos_reg,   pos_next;
    logic [PW-1:0]     start_reg, start_next;
    logic [PW-1:0]     count_reg, count_next;
    logic [NUM_KW-1:0] kw_reg,    kw_next;

    logic [7:0]        lc;
    logic [NUM_KW-1:0] hit;
    logic [4:0]        id_kind;
    logic [4:0]        pk;
    logic              fall;
    logic              pend_valid, new_valid;
    tok_t              pend_tok, new_tok;

    function automatic logic [PW-1:0] sat_inc(input logic [PW-1:0] v);
        return (v == POS_MAX) ? v : v + 1'b1;
    endfunction

    function automatic logic [OUT_W-1:0] clamp_out(input logic [PW-1:0] v);
        logic [CW-1:0] ext;
        ext = CW'(v);
        return (ext > CW'({OUT_W{1'b1}})) ? {OUT_W{1'b1}} : ext[OUT_W-1:0];
    endfunction

    assign lc  = to_lower(in_byte);
    assign hit = kw_hit(count_reg[2:0], lc) & {NUM_KW{count_reg < PW'(8)}};
    assign pk  = punct_kind(in_byte);

    // Lowest keyword index wins.
    always_comb begin
        id_kind = KIND_ID;
        for (int k = NUM_KW - 1; k >= 0; k--) begin
            if (kw_reg[k] && count_reg == PW'(KW_LEN[k])) begin
                id_kind = KIND_KW0 + 5'(k);
            end
        end
    end

    always_comb begin
        mode_next  = mode_reg;
        pos_next   = pos_reg;
        start_next = start_reg;
        count_next = count_reg;
        kw_next    = kw_reg;
        fall       = 1'b0;
        pend_valid = 1'b0;
        new_valid  = 1'b0;
        new_tok    = '0;

        pend_tok.start = clamp_out(start_reg);
        pend_tok.len   = clamp_out(count_reg);
        unique case (mode_reg)
            MODE_IDENT:  pend_tok.kind = id_kind;
            MODE_NUMBER: pend_tok.kind = KIND_INT;
            default:     pend_tok.kind = KIND_STRING;
        endcase

        if (in_end) begin
            pend_valid = (mode_reg == MODE_IDENT) || (mode_reg == MODE_NUMBER) ||
                         (mode_reg == MODE_STRING);
            new_valid  = 1'b1;
            new_tok    = '{kind: KIND_END, start: clamp_out(pos_reg), len: '0};
            mode_next  = MODE_IDLE;
            pos_next   = '0;
            start_next = '0;
            count_next = '0;
            kw_next    = '1;
        end else begin
            unique case (mode_reg)
                MODE_IDENT: begin
                    if (is_ident_char(in_byte)) begin
                        kw_next    = kw_reg & hit;
                        count_next = sat_inc(count_reg);
                        pos_next   = sat_inc(pos_reg);
                    end else begin
                        pend_valid = 1'b1;
                        fall       = 1'b1;
                    end
                end
                MODE_NUMBER: begin
                    if (is_digit(in_byte)) begin
                        count_next = sat_inc(count_reg);
                        pos_next   = sat_inc(pos_reg);
                    end else begin
                        pend_valid = 1'b1;
                        fall       = 1'b1;
                    end
                end
                MODE_STRING: begin
                    if (in_byte == "'") begin
                        pend_valid = 1'b1;
                        mode_next  = MODE_IDLE;
                    end else begin
                        count_next = sat_inc(count_reg);
                    end
                    pos_next = sat_inc(pos_reg);
                end
                MODE_IDLE: fall = 1'b1;
                default:   pos_next = sat_inc(pos_reg);
            endcase

            // Classify the byte as the start of a new token.
            if (fall) begin
                mode_next = MODE_IDLE;
                pos_next  = sat_inc(pos_reg);
                priority if (is_space(in_byte)) begin
                    mode_next = MODE_IDLE;
                end else if (is_letter(in_byte) || in_byte == "_") begin
                    mode_next  = MODE_IDENT;
                    start_next = pos_reg;
                    kw_next    = kw_hit(3'd0, lc);
                    count_next = PW'(1);
                end else if (is_digit(in_byte)) begin
                    mode_next  = MODE_NUMBER;
                    start_next = pos_reg;
                    count_next = PW'(1);
                end else if (in_byte == "'") begin
                    mode_next  = MODE_STRING;
                    start_next = sat_inc(pos_reg);
                    count_next = '0;
                end else if (pk != KIND_NONE) begin
                    new_valid = 1'b1;
                    new_tok   = '{kind: pk, start: clamp_out(pos_reg), len: OUT_W'(1)};
                end else begin
                    new_valid = 1'b1;
                    new_tok   = '{kind: KIND_ERROR, start: clamp_out(pos_reg),
                                  len: OUT_W'(1)};
                    mode_next = MODE_ERROR;
                end
            end
        end
    end

    always_comb begin
        push_entry.two = pend_valid && new_valid;
        push_entry.r0  = pend_valid ? pend_tok : new_tok;
        push_entry.r1  = new_tok;
    end

    assign push = accept && (pend_valid || new_valid);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_IDLE;
            pos_reg   <= '0;
            start_reg <= '0;
            count_reg <= '0;
            kw_reg    <= '1;
        end else if (accept) begin
            mode_reg  <= mode_next;
            pos_reg   <= pos_next;
            start_reg <= start_next;
            count_reg <= count_next;
            kw_reg    <= kw_next;
        end
    end

endmodule

FILE: rtl/core/sqll_fifo.sv
// ----------------------------------------------------------------------------
// sqll_fifo : result queue between scanner and output stage
// Show-ahead queue of result entries; the head is visible while not empty.
// ----------------------------------------------------------------------------
`include "sql_subset_lexer_defines.svh"

module sqll_fifo (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  sqll_pkg::entry_t push_entry,
    output logic             full,
    input  logic             pop,
    output sqll_pkg::entry_t head,
    output logic             empty
);
    import sqll_pkg::*;

    entry_t                mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [FIFO_CNT_W-1:0] count_reg;

    assign full  = (count_reg == FIFO_CNT_W'(FIFO_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            unique case ({push, pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    `SQLL_ASSERT_NOW(a_no_overflow, aclk, aresetn, push, !full)
    `SQLL_ASSERT_NOW(a_no_underflow, aclk, aresetn, pop, !empty)
    `SQLL_ASSERT_NEXT(a_count_tracks, aclk, aresetn, push && !pop,
                      count_reg == $past(count_reg) + 1'b1)

endmodule

FILE: rtl/core/sqll_back.sv
// ----------------------------------------------------------------------------
// sqll_back : output stage
// Splits each queue entry into one or two result beats and holds the beat
// in an output register until the receiver takes it.
// ----------------------------------------------------------------------------
`include "sql_subset_lexer_defines.svh"

module sqll_back (
    input  logic             aclk,
    input  logic             aresetn,
    input  sqll_pkg::entry_t head,
    input  logic             empty,
    output logic             pop,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [39:0]      m_tdata,
    output logic             m_tlast
);
    import sqll_pkg::*;

    logic valid_reg;
    logic phase_reg;
    tok_t tok_reg;
    logic last_reg;
    logic load;

    // Load a new beat when the register is free or being drained.
    assign load = (!valid_reg || m_tready) && !empty;
    assign pop  = load && (phase_reg || !head.two);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            phase_reg <= 1'b0;
        end else begin
            if (load) begin
                valid_reg <= 1'b1;
                phase_reg <= !phase_reg && head.two;
            end else if (m_tready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            tok_reg  <= phase_reg ? head.r1 : head.r0;
            last_reg <= phase_reg || !head.two;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tlast  = last_reg;
    assign m_tdata  = {3'b000, tok_reg.len, tok_reg.start, tok_reg.kind};

    `SQLL_ASSERT_NOW(a_phase_has_head, aclk, aresetn, phase_reg, !empty && head.two)
    `SQLL_ASSERT_NEXT(a_first_half_not_last, aclk, aresetn, load && !phase_reg && head.two,
                      phase_reg && !m_tlast)

endmodule

FILE: rtl/core/sql_subset_lexer.sv
// ----------------------------------------------------------------------------
// sql_subset_lexer : streaming lexical scanner for a small SQL subset
// Input beats carry one text byte or an end-of-statement flag; output beats
// carry tokens as kind, start offset and length.
// ----------------------------------------------------------------------------
// Input channel s_*: one byte per beat in s_tdata; s_tuser[0] set marks the
//   end of the statement (the byte is then ignored). The pending token is
//   flushed and an end token (kind 0) follows, after which position and
//   scan state return to their reset values.
// Output channel m_*: one token per beat; m_tlast marks the last token of an
//   input beat. After an error (kind 16) bytes are dropped until end of text.
// Throughput: one input beat per cycle while the queue is not full. A beat
//   that closes a token and starts a punctuation or error token, or an end
//   beat with a pending token, produces two output beats.
// A token is written into the queue, then loaded into the output register.
// A four-entry queue separates the scanner from the output register, so a
//   stalled receiver stops input only once the queue is full.
// Reset (aresetn low, synchronous): scan state idle, position zero, queue
//   and output register empty.
// ----------------------------------------------------------------------------
module sql_subset_lexer #(
    parameter int POS_WIDTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] text_byte
    input  logic [0:0]  s_tuser,   // [0] end_of_text
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [4:0] token_kind, [20:5] start_pos,
                                   // [36:21] token_length, [39:37] zero
    output logic        m_tlast    // last_of_run
);
    import sqll_pkg::*;

    logic   accept;
    logic   push;
    logic   pop;
    logic   full;
    logic   empty;
    entry_t push_entry;
    entry_t head;

    assign s_tready = !full;
    assign accept   = s_tvalid && s_tready;

    sqll_front #(
        .POS_WIDTH (POS_WIDTH)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (accept),
        .in_byte    (s_tdata),
        .in_end     (s_tuser[0]),
        .push       (push),
        .push_entry (push_entry)
    );

    sqll_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .full       (full),
        .pop        (pop),
        .head       (head),
        .empty      (empty)
    );

    sqll_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (head),
        .empty    (empty),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

FILE: tb/sv/tb_sql_subset_lexer.sv
// ----------------------------------------------------------------------------
// tb_sql_subset_lexer : self-checking testbench of the SQL subset lexer
// Drives text bytes and end flags on the input stream. A behavioral scanner
// computes the expected tokens of each accepted beat. Every output beat is
// compared, field by field, with the oldest pending token. Directed cases
// come first, then a long identifier, backpressure and random SQL-like
// statements.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_sql_subset_lexer;
    import sqll_pkg::*;

    localparam int          RANDOM_BEATS = 1200;
    localparam longint      CYCLE_LIMIT  = 4_000_000;
    localparam logic [15:0] POS_MAX      = 16'hFFFF;
    localparam logic [7:0]  QUOTE        = 8'h27;
    localparam string       IDENT_CHARS  =
        "_abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789";
    localparam int          IDENT_FIRST  = 53;   // underscore and letters
    localparam string       MARKS        = ",()*=;";
    localparam string       KW_WORD [6]  = '{
        "select", "insert", "into", "values", "from", "where"
    };

    typedef enum logic [2:0] {
        SCAN_IDLE, SCAN_WORD, SCAN_DIGITS, SCAN_QUOTED, SCAN_ERROR
    } scan_mode_t;

    typedef struct packed {
        logic [4:0]  kind;
        logic [15:0] start;
        logic [15:0] len;
        logic        last;
    } token_t;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic [0:0]  s_tuser  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;   // [4:0] token_kind, [20:5] start_pos,
                            // [36:21] token_length, [39:37] zero
    logic        m_tlast;

    token_t      pending_tokens [$];
    token_t      beat_tokens [$];
    int          errors       = 0;
    int          beats_sent   = 0;
    int          rx_hold_req  = 0;
    bit          tx_gaps_on   = 1'b1;
    bit          rx_stalls_on = 1'b1;
    longint      cycle_count  = 0;

    // Scanner state mirrored by the predictor
    scan_mode_t  lex_mode;
    logic [15:0] lex_pos;
    logic [15:0] lex_start;
    logic [15:0] lex_count;
    logic [5:0]  lex_kw_alive;

    sql_subset_lexer #(.POS_WIDTH(16)) uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Verification failed");
        $finish;
    end

    // Mostly short gaps, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // ------------------------------------------------------------------
    // Token predictor
    // ------------------------------------------------------------------
    function automatic logic [15:0] sat_inc(input logic [15:0] v);
        return (v == POS_MAX) ? v : v + 16'd1;
    endfunction

    function automatic bit ch_alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic bit ch_num(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit ch_blank(input logic [7:0] c);
        return c == " " || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic bit ch_word(input logic [7:0] c);
        return ch_alpha(c) || ch_num(c) || c == "_";
    endfunction

    function automatic logic [4:0] mark_kind(input logic [7:0] c);
        case (c)
            ",":     return KIND_COMMA;
            "(":     return KIND_LPAREN;
            ")":     return KIND_RPAREN;
            "*":     return KIND_STAR;
            "=":     return KIND_EQUAL;
            ";":     return KIND_SEMI;
            default: return KIND_NONE;
        endcase
    endfunction

    // Drop every keyword whose character at idx differs from c
    function automatic void kw_narrow(input int idx, input logic [7:0] c);
        logic [7:0] lc;
        lc = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
        for (int k = 0; k < 6; k++) begin
            if (!(idx < KW_WORD[k].len() && KW_WORD[k][idx] == lc))
                lex_kw_alive[k] = 1'b0;
        end
    endfunction

    function automatic logic [4:0] word_kind();
        for (int k = 0; k < 6; k++) begin
            if (lex_kw_alive[k] && lex_count == 16'(KW_WORD[k].len()))
                return KIND_KW0 + 5'(k);
        end
        return KIND_ID;
    endfunction

    function automatic void emit_token(input logic [4:0] kind, input logic [15:0] start,
                                       input logic [15:0] len);
        beat_tokens.push_back('{kind, start, len, 1'b0});
    endfunction

    function automatic void flush_open_token();
        case (lex_mode)
            SCAN_WORD:   emit_token(word_kind(), lex_start, lex_count);
            SCAN_DIGITS: emit_token(KIND_INT, lex_start, lex_count);
            SCAN_QUOTED: emit_token(KIND_STRING, lex_start, lex_count);
            default: ;
        endcase
    endfunction

    function automatic void lex_clear();
        lex_mode     = SCAN_IDLE;
        lex_pos      = '0;
        lex_start    = '0;
        lex_count    = '0;
        lex_kw_alive = '1;
    endfunction

    // Expected tokens of one accepted beat, appended to pending_tokens
    function automatic void lex_predict(input logic [7:0] c, input logic eot);
        bit classify;
        token_t t;
        beat_tokens.delete();
        classify = 1'b0;
        if (eot) begin
            flush_open_token();
            emit_token(KIND_END, lex_pos, 16'd0);
            lex_clear();
        end else begin
            case (lex_mode)
                SCAN_WORD: begin
                    if (ch_word(c)) begin
                        kw_narrow(int'(lex_count), c);
                        lex_count = sat_inc(lex_count);
                        lex_pos   = sat_inc(lex_pos);
                    end else begin
                        flush_open_token();
                        lex_mode = SCAN_IDLE;
                        classify = 1'b1;
                    end
                end
                SCAN_DIGITS: begin
                    if (ch_num(c)) begin
                        lex_count = sat_inc(lex_count);
                        lex_pos   = sat_inc(lex_pos);
                    end else begin
                        flush_open_token();
                        lex_mode = SCAN_IDLE;
                        classify = 1'b1;
                    end
                end
                SCAN_QUOTED: begin
                    if (c == QUOTE) begin
                        flush_open_token();
                        lex_mode = SCAN_IDLE;
                    end else begin
                        lex_count = sat_inc(lex_count);
                    end
                    lex_pos = sat_inc(lex_pos);
                end
                SCAN_IDLE: classify = 1'b1;
                default:   lex_pos = sat_inc(lex_pos);
            endcase
            if (classify) begin
                if (ch_blank(c)) begin
                    // skip
                end else if (ch_alpha(c) || c == "_") begin
                    lex_mode     = SCAN_WORD;
                    lex_start    = lex_pos;
                    lex_kw_alive = '1;
                    kw_narrow(0, c);
                    lex_count    = 16'd1;
                end else if (ch_num(c)) begin
                    lex_mode  = SCAN_DIGITS;
                    lex_start = lex_pos;
                    lex_count = 16'd1;
                end else if (c == QUOTE) begin
                    lex_mode  = SCAN_QUOTED;
                    lex_start = sat_inc(lex_pos);
                    lex_count = 16'd0;
                end else if (mark_kind(c) != KIND_NONE) begin
                    emit_token(mark_kind(c), lex_pos, 16'd1);
                end else begin
                    emit_token(KIND_ERROR, lex_pos, 16'd1);
                    lex_mode = SCAN_ERROR;
                end
                lex_pos = sat_inc(lex_pos);
            end
        end
        foreach (beat_tokens[i]) begin
            t      = beat_tokens[i];
            t.last = (i == beat_tokens.size() - 1);
            pending_tokens.push_back(t);
        end
    endfunction

    // ------------------------------------------------------------------
    // Output side: ready pattern and token checker
    // ------------------------------------------------------------------
    initial begin : rx_ready
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left  = 0;
        forever begin
            @(posedge aclk);
            if (rx_hold_req != 0) begin
                hold_left   = rx_hold_req;
                rx_hold_req = 0;
            end
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else if (!rx_stalls_on) begin
                m_tready <= 1'b1;
            end else if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else begin
                m_tready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    stall_left = gap_len();
            end
        end
    end

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endfunction

    always @(posedge aclk) begin : token_check
        token_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_tokens.size() == 0) begin
                $display("%0t: unexpected token, expected none, actual kind %0d start %0d len %0d",
                         $time, m_tdata[4:0], m_tdata[20:5], m_tdata[36:21]);
                errors++;
            end else begin
                want = pending_tokens.pop_front();
                check_field("token_kind", want.kind, m_tdata[4:0]);
                check_field("start_pos", want.start, m_tdata[20:5]);
                check_field("token_length", want.len, m_tdata[36:21]);
                check_field("last_of_run", want.last, m_tlast);
            end
        end
    end

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------
    task automatic send_beat(input logic [7:0] b, input logic eot);
        int gap;
        gap = tx_gaps_on ? gap_len() : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= eot;
        do @(posedge aclk); while (!s_tready);
        lex_predict(b, eot);
        beats_sent++;
    endtask

    task automatic send_text(input string txt);
        for (int i = 0; i < txt.len(); i++)
            send_beat(txt[i], 1'b0);
    endtask

    task automatic end_statement();
        send_beat(8'($urandom_range(0, 255)), 1'b1);
    endtask

    // Drop valid and hold until every expected token has come out
    task automatic wait_for_tokens();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_tokens.size() != 0);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_marks_and_keyword();
        send_text(",()*=;_");
        send_beat(8'h00, 1'b1);
        send_text("Into");
        send_beat(8'd9, 1'b0);
        end_statement();
    endtask

    // Digit run ending at a letter, high byte as unknown, bytes after error dropped
    task automatic test_adjacent_and_error();
        send_text("9a");
        send_beat(8'hFF, 1'b0);
        send_text("x'");
        send_beat(8'hFF, 1'b1);
    endtask

    // Zero byte is unknown outside a string, plain text inside; end closes string
    task automatic test_zero_byte_and_open_string();
        send_beat(8'h00, 1'b0);
        end_statement();
        send_beat(QUOTE, 1'b0);
        send_beat(8'h00, 1'b0);
        send_beat(8'h80, 1'b0);
        send_beat(8'h7F, 1'b1);
    endtask

    // Identifier far longer than any keyword, sent back to back
    task automatic test_long_identifier();
        tx_gaps_on = 1'b0;
        send_beat("Q", 1'b0);
        for (int i = 0; i < 199; i++)
            send_beat(IDENT_CHARS[$urandom_range(0, IDENT_CHARS.len() - 1)], 1'b0);
        send_text(" 7");
        end_statement();
        tx_gaps_on = 1'b1;
        wait_for_tokens();
    endtask

    // Receiver holds off while marks stream in, filling the output queue
    task automatic test_backpressure();
        tx_gaps_on  = 1'b0;
        rx_hold_req = 300;
        for (int i = 0; i < 40; i++)
            send_beat(MARKS[$urandom_range(0, MARKS.len() - 1)], 1'b0);
        end_statement();
        tx_gaps_on = 1'b1;
        wait_for_tokens();
    endtask

    task automatic send_blanks(input int n);
        logic [7:0] c;
        for (int i = 0; i < n; i++) begin
            c = ($urandom_range(0, 1) == 0) ? " " : 8'($urandom_range(9, 13));
            send_beat(c, 1'b0);
        end
    endtask

    task automatic send_random_statement();
        bit         broken;
        int         r;
        int         n;
        logic [7:0] c;
        string      w;
        broken = ($urandom_range(0, 4) == 0);
        n      = $urandom_range(1, 12);
        for (int t = 0; t < n; t++) begin
            r = $urandom_range(0, 99);
            if (r < 25) begin
                w = KW_WORD[$urandom_range(0, 5)];
                for (int i = 0; i < w.len(); i++) begin
                    c = w[i];
                    send_beat($urandom_range(0, 1) ? c - 8'd32 : c, 1'b0);
                end
            end else if (r < 45) begin
                send_beat(IDENT_CHARS[$urandom_range(0, IDENT_FIRST - 1)], 1'b0);
                repeat ($urandom_range(0, 9))
                    send_beat(IDENT_CHARS[$urandom_range(0, IDENT_CHARS.len() - 1)], 1'b0);
            end else if (r < 60) begin
                repeat ($urandom_range(1, 6))
                    send_beat(8'("0" + $urandom_range(0, 9)), 1'b0);
            end else if (r < 72) begin
                send_beat(QUOTE, 1'b0);
                repeat ($urandom_range(0, 8)) begin
                    do c = 8'($urandom_range(0, 255)); while (c == QUOTE);
                    send_beat(c, 1'b0);
                end
                // broken statements may leave the string open at the end
                if (!(broken && t == n - 1))
                    send_beat(QUOTE, 1'b0);
            end else if (r < 92 || !broken) begin
                send_beat(MARKS[$urandom_range(0, MARKS.len() - 1)], 1'b0);
            end else begin
                send_beat(8'($urandom_range(0, 255)), 1'b0);
            end
            send_blanks(($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 2));
        end
        end_statement();
    endtask

    task automatic test_random_statements();
        int first;
        first = beats_sent;
        while (beats_sent - first < RANDOM_BEATS) begin
            tx_gaps_on   = ($urandom_range(0, 3) != 0);
            rx_stalls_on = ($urandom_range(0, 3) != 0);
            send_random_statement();
            // pause the sender now and then until the output has caught up
            if ($urandom_range(0, 15) == 0)
                wait_for_tokens();
        end
    endtask

    initial begin
        lex_clear();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        test_marks_and_keyword();
        test_adjacent_and_error();
        test_zero_byte_and_open_string();
        wait_for_tokens();
        test_long_identifier();
        test_backpressure();
        test_random_statements();
        wait_for_tokens();
        repeat (20) @(posedge aclk);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/sqll_pkg.sv
rtl/core/sqll_front.sv
rtl/core/sqll_fifo.sv
rtl/core/sqll_back.sv
rtl/core/sql_subset_lexer.sv
tb/sv/tb_sql_subset_lexer.sv
